/* rtl/core/ecc_pkg.sv */
// Epoch calendar converter package: payload structs, sequencer states,
// arithmetic unit request/response types, calendar constants and month table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ecc_pkg;

  localparam logic OP_TO_COUNT = 1'b0;
  localparam logic OP_TO_DATE  = 1'b1;

  localparam logic [31:0] SECS_LEAP_YEAR   = 32'd31622400;
  localparam logic [31:0] SECS_COMMON_YEAR = 32'd31536000;
  localparam logic [31:0] SECS_PER_DAY     = 32'd86400;
  localparam logic [31:0] SECS_PER_HOUR    = 32'd3600;
  localparam logic [31:0] SECS_PER_MIN     = 32'd60;
  localparam logic [31:0] DAYS_LEAP_YEAR   = 32'd366;
  localparam logic [31:0] DAYS_COMMON_YEAR = 32'd365;

  localparam logic [11:0] YEAR_FIRST = 12'd1970;
  localparam logic [11:0] YEAR_LAST  = 12'd2099;

  localparam logic [1:0] MOD4_FIRST   = 2'd2;
  localparam logic [6:0] MOD100_FIRST = 7'd70;
  localparam logic [8:0] MOD400_FIRST = 9'd370;
  localparam logic [6:0] MOD100_LAST  = 7'd99;
  localparam logic [8:0] MOD400_LAST  = 9'd399;

  localparam logic [3:0] MONTHS       = 4'd12;
  localparam logic [3:0] MONTH_LAST   = 4'd11;
  localparam logic [3:0] DIV_DAY_TOP  = 4'd15;
  localparam logic [3:0] DIV_HOUR_TOP = 4'd4;
  localparam logic [3:0] DIV_MIN_TOP  = 4'd5;

  typedef struct packed {
    logic        op;
    logic [11:0] year_in;
    logic [3:0]  month_in;
    logic [4:0]  day_in;
    logic [4:0]  hour_in;
    logic [5:0]  minute_in;
    logic [5:0]  sec_in;
    logic [31:0] count_in;
  } ecc_in_t;

  typedef struct packed {
    logic        status;
    logic [31:0] count_out;
    logic [11:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [4:0]  hour_out;
    logic [5:0]  minute_out;
    logic [5:0]  sec_out;
  } ecc_out_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic        sub;
  } alu_req_t;

  typedef struct packed {
    logic [31:0] sum;
    logic        ge;
  } alu_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_C_YEAR,
    ST_C_MON,
    ST_C_DADJ,
    ST_C_DAYS,
    ST_C_HOUR,
    ST_C_MIN,
    ST_C_SEC,
    ST_D_DIV,
    ST_D_YEAR,
    ST_D_MON,
    ST_D_HOUR,
    ST_D_MIN,
    ST_DONE
  } state_t;

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd0:    len = 5'd31;
      4'd1:    len = leap ? 5'd29 : 5'd28;
      4'd2:    len = 5'd31;
      4'd3:    len = 5'd30;
      4'd4:    len = 5'd31;
      4'd5:    len = 5'd30;
      4'd6:    len = 5'd31;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd30;
      4'd9:    len = 5'd31;
      4'd10:   len = 5'd30;
      4'd11:   len = 5'd31;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/ecc_alu.sv */
// Shared 32-bit add/subtract unit with no-borrow flag for the converter.
// Depends on ecc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ecc_alu (
  input  ecc_pkg::alu_req_t req,
  output ecc_pkg::alu_rsp_t rsp
);

  logic [32:0] wide;

  assign wide = {1'b0, req.a} + {1'b0, (req.sub ? ~req.b : req.b)} + 33'(req.sub);

  always_comb begin
    rsp.sum = wide[31:0];
    rsp.ge  = wide[32];
  end

endmodule

`default_nettype wire

/* rtl/core/epoch_calendar_converter.sv */
// Epoch calendar converter: one transaction at a time, one shared add/subtract unit.
// Date to count: year and month accumulation, day adjust, then day, hour, minute and
// second terms. Count to date: 16-step day division, year/month peel, 5- and 6-step
// hour/minute division. busy drops as the strobe rises, so the next transaction can be
// accepted in the strobe cycle.
// The result strobe lasts one cycle; the receiver cannot stall it.
// Synchronous active-low reset returns the sequencer to idle; datapath is not reset.
`timescale 1ns / 1ps
`default_nettype none

module epoch_calendar_converter (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  ecc_pkg::ecc_in_t  in_item,
  output logic              out_valid,
  output ecc_pkg::ecc_out_t out_item
);

  ecc_pkg::state_t   state_r, state_nxt;
  ecc_pkg::ecc_in_t  item_r, item_nxt;
  ecc_pkg::ecc_out_t out_item_r, out_item_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [31:0]       acc_r, acc_nxt;
  logic [11:0]       year_r, year_nxt;
  logic [1:0]        m4_r, m4_nxt;
  logic [6:0]        m100_r, m100_nxt;
  logic [8:0]        m400_r, m400_nxt;
  logic [3:0]        idx_r, idx_nxt;
  logic [15:0]       days_r, days_nxt;
  logic [4:0]        hour_r, hour_nxt;
  logic [5:0]        min_r, min_nxt;
  logic [3:0]        mon_r, mon_nxt;
  logic              err_r, err_nxt;

  ecc_pkg::alu_req_t alu_req;
  ecc_pkg::alu_rsp_t alu_rsp;

  logic       leap;
  logic       in_year_bad;
  logic [3:0] mon_m1;
  logic [3:0] months_before;
  logic [4:0] mon_len;

  ecc_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign leap = ((m4_r == 2'd0) && (m100_r != 7'd0)) || (m400_r == 9'd0);
  assign in_year_bad = (in_item.year_in < ecc_pkg::YEAR_FIRST) ||
                       (in_item.year_in > ecc_pkg::YEAR_LAST);
  assign mon_m1 = item_r.month_in - 4'd1;
  assign months_before = (item_r.month_in == 4'd0) ? 4'd0 :
                         ((mon_m1 > ecc_pkg::MONTHS) ? ecc_pkg::MONTHS : mon_m1);
  assign mon_len = ecc_pkg::month_days(idx_r, leap);

  assign busy      = (state_r != ecc_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ecc_pkg::ST_IDLE: begin
        if (start) begin
          if (in_item.op == ecc_pkg::OP_TO_DATE) begin
            state_nxt = ecc_pkg::ST_D_DIV;
          end else if (in_year_bad) begin
            state_nxt = ecc_pkg::ST_DONE;
          end else begin
            state_nxt = ecc_pkg::ST_C_YEAR;
          end
        end
      end
      ecc_pkg::ST_C_YEAR: begin
        if (year_r == item_r.year_in) state_nxt = ecc_pkg::ST_C_MON;
      end
      ecc_pkg::ST_C_MON: begin
        if (idx_r == months_before) state_nxt = ecc_pkg::ST_C_DADJ;
      end
      ecc_pkg::ST_C_DADJ: state_nxt = ecc_pkg::ST_C_DAYS;
      ecc_pkg::ST_C_DAYS: state_nxt = ecc_pkg::ST_C_HOUR;
      ecc_pkg::ST_C_HOUR: state_nxt = ecc_pkg::ST_C_MIN;
      ecc_pkg::ST_C_MIN:  state_nxt = ecc_pkg::ST_C_SEC;
      ecc_pkg::ST_C_SEC:  state_nxt = ecc_pkg::ST_DONE;
      ecc_pkg::ST_D_DIV: begin
        if (idx_r == 4'd0) state_nxt = ecc_pkg::ST_D_YEAR;
      end
      ecc_pkg::ST_D_YEAR: begin
        if (!alu_rsp.ge) state_nxt = ecc_pkg::ST_D_MON;
      end
      ecc_pkg::ST_D_MON: begin
        if ((idx_r == ecc_pkg::MONTHS) || !alu_rsp.ge) state_nxt = ecc_pkg::ST_D_HOUR;
      end
      ecc_pkg::ST_D_HOUR: begin
        if (idx_r == 4'd0) state_nxt = ecc_pkg::ST_D_MIN;
      end
      ecc_pkg::ST_D_MIN: begin
        if (idx_r == 4'd0) state_nxt = ecc_pkg::ST_DONE;
      end
      ecc_pkg::ST_DONE: state_nxt = ecc_pkg::ST_IDLE;
      default:          state_nxt = ecc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    alu_req.a   = acc_r;
    alu_req.b   = 32'd0;
    alu_req.sub = 1'b0;
    unique case (state_r)
      ecc_pkg::ST_C_YEAR: begin
        alu_req.b = leap ? ecc_pkg::SECS_LEAP_YEAR : ecc_pkg::SECS_COMMON_YEAR;
      end
      ecc_pkg::ST_C_MON: begin
        alu_req.b = 32'(mon_len) * ecc_pkg::SECS_PER_DAY;
      end
      ecc_pkg::ST_C_DADJ: begin
        alu_req.b   = ecc_pkg::SECS_PER_DAY;
        alu_req.sub = 1'b1;
      end
      ecc_pkg::ST_C_DAYS: begin
        alu_req.b = 32'(item_r.day_in) * ecc_pkg::SECS_PER_DAY;
      end
      ecc_pkg::ST_C_HOUR: begin
        alu_req.b = 32'(item_r.hour_in) * ecc_pkg::SECS_PER_HOUR;
      end
      ecc_pkg::ST_C_MIN: begin
        alu_req.b = 32'(item_r.minute_in) * ecc_pkg::SECS_PER_MIN;
      end
      ecc_pkg::ST_C_SEC: begin
        alu_req.b = 32'(item_r.sec_in);
      end
      ecc_pkg::ST_D_DIV: begin
        alu_req.b   = ecc_pkg::SECS_PER_DAY << idx_r;
        alu_req.sub = 1'b1;
      end
      ecc_pkg::ST_D_YEAR: begin
        alu_req.a   = 32'(days_r);
        alu_req.b   = leap ? ecc_pkg::DAYS_LEAP_YEAR : ecc_pkg::DAYS_COMMON_YEAR;
        alu_req.sub = 1'b1;
      end
      ecc_pkg::ST_D_MON: begin
        alu_req.a   = 32'(days_r);
        alu_req.b   = 32'(mon_len);
        alu_req.sub = 1'b1;
      end
      ecc_pkg::ST_D_HOUR: begin
        alu_req.b   = ecc_pkg::SECS_PER_HOUR << idx_r;
        alu_req.sub = 1'b1;
      end
      ecc_pkg::ST_D_MIN: begin
        alu_req.b   = ecc_pkg::SECS_PER_MIN << idx_r;
        alu_req.sub = 1'b1;
      end
      default: begin
        alu_req.sub = 1'b0;
      end
    endcase
  end

  always_comb begin
    item_nxt      = item_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = 1'b0;
    acc_nxt       = acc_r;
    year_nxt      = year_r;
    m4_nxt        = m4_r;
    m100_nxt      = m100_r;
    m400_nxt      = m400_r;
    idx_nxt       = idx_r;
    days_nxt      = days_r;
    hour_nxt      = hour_r;
    min_nxt       = min_r;
    mon_nxt       = mon_r;
    err_nxt       = err_r;
    unique case (state_r)
      ecc_pkg::ST_IDLE: begin
        if (start) begin
          item_nxt = in_item;
          acc_nxt  = (in_item.op == ecc_pkg::OP_TO_DATE) ? in_item.count_in : 32'd0;
          year_nxt = ecc_pkg::YEAR_FIRST;
          m4_nxt   = ecc_pkg::MOD4_FIRST;
          m100_nxt = ecc_pkg::MOD100_FIRST;
          m400_nxt = ecc_pkg::MOD400_FIRST;
          days_nxt = 16'd0;
          err_nxt  = (in_item.op == ecc_pkg::OP_TO_COUNT) && in_year_bad;
          idx_nxt  = (in_item.op == ecc_pkg::OP_TO_DATE) ? ecc_pkg::DIV_DAY_TOP : 4'd0;
        end
      end
      ecc_pkg::ST_C_YEAR: begin
        if (year_r != item_r.year_in) begin
          acc_nxt  = alu_rsp.sum;
          year_nxt = year_r + 12'd1;
          m4_nxt   = m4_r + 2'd1;
          m100_nxt = (m100_r == ecc_pkg::MOD100_LAST) ? 7'd0 : m100_r + 7'd1;
          m400_nxt = (m400_r == ecc_pkg::MOD400_LAST) ? 9'd0 : m400_r + 9'd1;
        end
      end
      ecc_pkg::ST_C_MON: begin
        if (idx_r != months_before) begin
          acc_nxt = alu_rsp.sum;
          idx_nxt = idx_r + 4'd1;
        end
      end
      ecc_pkg::ST_C_DADJ: begin
        acc_nxt = alu_rsp.sum;
      end
      ecc_pkg::ST_C_DAYS: begin
        acc_nxt = alu_rsp.sum;
      end
      ecc_pkg::ST_C_HOUR: begin
        acc_nxt = alu_rsp.sum;
      end
      ecc_pkg::ST_C_MIN: begin
        acc_nxt = alu_rsp.sum;
      end
      ecc_pkg::ST_C_SEC: begin
        acc_nxt = alu_rsp.sum;
      end
      ecc_pkg::ST_D_DIV: begin
        if (alu_rsp.ge) acc_nxt = alu_rsp.sum;
        days_nxt = {days_r[14:0], alu_rsp.ge};
        idx_nxt  = idx_r - 4'd1;
      end
      ecc_pkg::ST_D_YEAR: begin
        if (alu_rsp.ge) begin
          days_nxt = alu_rsp.sum[15:0];
          year_nxt = year_r + 12'd1;
          m4_nxt   = m4_r + 2'd1;
          m100_nxt = (m100_r == ecc_pkg::MOD100_LAST) ? 7'd0 : m100_r + 7'd1;
          m400_nxt = (m400_r == ecc_pkg::MOD400_LAST) ? 9'd0 : m400_r + 9'd1;
        end else begin
          idx_nxt = 4'd0;
        end
      end
      ecc_pkg::ST_D_MON: begin
        if ((idx_r != ecc_pkg::MONTHS) && alu_rsp.ge) begin
          days_nxt = alu_rsp.sum[15:0];
          idx_nxt  = idx_r + 4'd1;
        end else begin
          mon_nxt = (idx_r > ecc_pkg::MONTH_LAST) ? ecc_pkg::MONTH_LAST : idx_r;
          idx_nxt = ecc_pkg::DIV_HOUR_TOP;
        end
      end
      ecc_pkg::ST_D_HOUR: begin
        if (alu_rsp.ge) acc_nxt = alu_rsp.sum;
        hour_nxt = {hour_r[3:0], alu_rsp.ge};
        idx_nxt  = (idx_r == 4'd0) ? ecc_pkg::DIV_MIN_TOP : idx_r - 4'd1;
      end
      ecc_pkg::ST_D_MIN: begin
        if (alu_rsp.ge) acc_nxt = alu_rsp.sum;
        min_nxt = {min_r[4:0], alu_rsp.ge};
        idx_nxt = idx_r - 4'd1;
      end
      ecc_pkg::ST_DONE: begin
        out_valid_nxt = 1'b1;
        out_item_nxt  = '0;
        if (item_r.op == ecc_pkg::OP_TO_COUNT) begin
          out_item_nxt.status    = err_r;
          out_item_nxt.count_out = err_r ? 32'd0 : acc_r;
        end else begin
          out_item_nxt.year_out   = year_r;
          out_item_nxt.month_out  = mon_r + 4'd1;
          out_item_nxt.day_out    = days_r[4:0] + 5'd1;
          out_item_nxt.hour_out   = hour_r;
          out_item_nxt.minute_out = min_r;
          out_item_nxt.sec_out    = acc_r[5:0];
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ecc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    out_item_r <= out_item_nxt;
    acc_r      <= acc_nxt;
    year_r     <= year_nxt;
    m4_r       <= m4_nxt;
    m100_r     <= m100_nxt;
    m400_r     <= m400_nxt;
    idx_r      <= idx_nxt;
    days_r     <= days_nxt;
    hour_r     <= hour_nxt;
    min_r      <= min_nxt;
    mon_r      <= mon_nxt;
    err_r      <= err_nxt;
  end

endmodule

`default_nettype wire
